/* hw/rtl/ult_pkg.sv */
// Shared types, codes and widths for the unsorted list table.
`timescale 1ns / 1ps
`default_nettype none

package ult_pkg;

   // Fixed field widths of the transaction ports
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Default sizing of the list
   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESET    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_NEXT     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_PAST = 2'd3;

   // Shift command broadcast to every cell of the row
   typedef struct packed {
      logic ins;   // take the left neighbour's entry
      logic del;   // take the right neighbour's entry at or beyond the first hit
   } ult_shift_type;

endpackage

`default_nettype wire

/* hw/rtl/ult_cell.sv */
// One storage cell of the list: holds an entry, compares it and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module ult_cell #(
   parameter int WIDTH = ult_pkg::WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire ult_pkg::ult_shift_type shift,
   input  wire logic                  occupied,
   input  wire logic [WIDTH-1:0]      key,
   input  wire logic [WIDTH-1:0]      left_value,
   input  wire logic [WIDTH-1:0]      right_value,
   input  wire logic                  hit_in,
   output logic                       hit_out,
   output logic [WIDTH-1:0]           value
);
   import ult_pkg::*;

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;
   logic             hit_here;

   assign hit_here = occupied && (value_ff == key);
   // Hit at this cell or anywhere nearer the head
   assign hit_out  = hit_in | hit_here;
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (shift.ins) begin
         value_in = left_value;
      end else if (shift.del && hit_out) begin
         // close the gap left by the removed entry
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/unsorted_list_table_unit.sv */
// Top level of the unsorted list table: row of cells, count, cursor and result register.
// The response to an accepted request is loaded into the output register at the next clock edge.
// Throughput: one transaction per cycle unless stalled; every cell compares and shifts in the same cycle.
// The request side stalls while a held response is not taken and stays ready while it is being taken.
// Reset clears the entry count, the cursor and the response valid; entry contents
// are left as they are and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none

module unsorted_list_table_unit #(
   parameter int DEPTH = ult_pkg::DEPTH_DEF,
   parameter int WIDTH = ult_pkg::WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ult_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [ult_pkg::VALUE_W-1:0]   req_item_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic [ult_pkg::VALUE_W-1:0]        rsp_out_value,
   output logic [ult_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_at_end,
   output logic [ult_pkg::STATUS_W-1:0]       rsp_status
);
   import ult_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic              accept;
   logic [WIDTH-1:0]  key;
   logic [WIDTH-1:0]  cell_value [DEPTH];
   logic [DEPTH:0]    hit_chain;
   logic              any_hit;
   logic              full;
   logic [WIDTH-1:0]  cursor_entry;
   ult_shift_type     shift;

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     cursor_ff, cursor_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic [VALUE_W-1:0]  out_value_ff, out_value_in;
   logic [COUNT_W-1:0]  count_out_ff;
   logic                at_end_ff;
   logic [STATUS_W-1:0] status_ff, status_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign key       = WIDTH'(req_item_value);

   assign hit_chain[0] = 1'b0;
   assign any_hit      = hit_chain[DEPTH];
   assign full         = (count_ff == CW'(DEPTH));

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_value;
      logic [WIDTH-1:0] right_value;
      logic             occupied;

      assign occupied = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_value = key;
      end else begin : g_body
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      ult_cell #(
         .WIDTH (WIDTH)
      ) u_cell (
         .clock       (clock),
         .shift       (shift),
         .occupied    (occupied),
         .key         (key),
         .left_value  (left_value),
         .right_value (right_value),
         .hit_in      (hit_chain[i]),
         .hit_out     (hit_chain[i+1]),
         .value       (cell_value[i])
      );
   end

   // Select the entry under the cursor
   always_comb begin
      cursor_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cursor_ff == CW'(i)) begin
            cursor_entry = cell_value[i];
         end
      end
   end

   always_comb begin
      shift        = '0;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      found_in     = 1'b0;
      out_value_in = '0;
      status_in    = STATUS_OK;
      case (req_func)
         FUNC_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               shift.ins = 1'b1;
               count_in  = count_ff + CW'(1);
            end
         end
         FUNC_RETRIEVE: begin
            // a hit means the stored entry equals the key
            found_in = any_hit;
            if (any_hit) begin
               out_value_in = VALUE_W'(key);
            end
         end
         FUNC_DELETE: begin
            if (any_hit) begin
               found_in  = 1'b1;
               shift.del = 1'b1;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = STATUS_MISS;
            end
         end
         FUNC_RESET: begin
            cursor_in = '0;
         end
         FUNC_NEXT: begin
            if (cursor_ff < count_ff) begin
               out_value_in = VALUE_W'(cursor_entry);
               cursor_in    = cursor_ff + CW'(1);
            end else begin
               status_in = STATUS_PAST;
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      // drop all updates unless the request is taken
      if (!accept) begin
         shift     = '0;
         count_in  = count_ff;
         cursor_in = cursor_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff     <= found_in;
         out_value_ff <= out_value_in;
         count_out_ff <= COUNT_W'(count_in);
         at_end_ff    <= (cursor_in >= count_in);
         status_ff    <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_count     = count_out_ff;
   assign rsp_at_end    = at_end_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire
